// ===== hdl/pbm_pkg.sv =====
// shared types and constants for the page bitmap allocator
package pbm_pkg;

    // fixed field widths
    localparam int unsigned PAGE_W  = 16;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned LIMIT_W = 17;
    localparam int unsigned HINT_W  = 17;
    localparam int unsigned OP_W    = 3;

    // page limit after reset
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;

    // operation codes
    localparam logic [OP_W-1:0] OP_FREE_ONE   = 3'd0;
    localparam logic [OP_W-1:0] OP_USE_ONE    = 3'd1;
    localparam logic [OP_W-1:0] OP_FREE_RANGE = 3'd2;
    localparam logic [OP_W-1:0] OP_USE_RANGE  = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;
    localparam logic [OP_W-1:0] OP_FILL       = 3'd5;

    // request beat
    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [PAGE_W-1:0]  page_number;
        logic [COUNT_W-1:0] range_count;
        logic               fill_value;
    } req_t;

    // result beat
    typedef struct packed {
        logic              ok;
        logic              page_used;
        logic [HINT_W-1:0] next_free_hint;
    } rsp_t;

    // controller states
    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_WR,
        ST_FINISH
    } state_t;

endpackage

// ===== hdl/pbm_map_ram.sv =====
// bitmap word memory, one write port and one registered read port
module pbm_map_ram #(
    parameter int unsigned DEPTH     = 1024,
    parameter int unsigned WORD_BITS = 64,
    parameter int unsigned ADDR_W    = 10
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] map_mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            map_mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/pbm_ctrl.sv =====
// request decode, word walker, fill sweep and hint update
module pbm_ctrl #(
    parameter int unsigned MAX_PAGES = 65536,
    parameter int unsigned WORD_BITS = 64,
    parameter int unsigned ADDR_W    = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [pbm_pkg::LIMIT_W-1:0] page_limit,
    input  pbm_pkg::req_t               req,
    input  logic                        req_valid,
    output logic                        req_ready,
    output pbm_pkg::rsp_t               rsp,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic                        wr_en,
    output logic [ADDR_W-1:0]           wr_addr,
    output logic [WORD_BITS-1:0]        wr_data,
    output logic                        rd_en,
    output logic [ADDR_W-1:0]           rd_addr,
    input  logic [WORD_BITS-1:0]        rd_data
);

    localparam int unsigned DEPTH  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned OFF_W  = $clog2(WORD_BITS);
    localparam int unsigned K_W    = OFF_W + 1;
    localparam int unsigned CMP_W  =
        ($clog2(MAX_PAGES + 1) > 18) ? $clog2(MAX_PAGES + 1) : 18;
    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(DEPTH - 1);

    pbm_pkg::state_t state_reg, state_next;

    logic [pbm_pkg::OP_W-1:0]    op_reg;
    logic [pbm_pkg::PAGE_W-1:0]  page_reg;
    logic [pbm_pkg::COUNT_W-1:0] count_reg;
    logic                        fill_reg;
    logic                        ok_reg;
    logic [ADDR_W-1:0]           word_reg;
    logic [OFF_W-1:0]            off_reg;
    logic [pbm_pkg::COUNT_W-1:0] rem_reg;
    logic [ADDR_W-1:0]           sweep_reg;
    logic                        sweep_rsp_reg;
    logic [pbm_pkg::HINT_W-1:0]  hint_reg;

    logic                        accept;
    logic [CMP_W-1:0]            eff_lim;
    logic [CMP_W-1:0]            in_p;
    logic [CMP_W-1:0]            in_n;
    logic                        single_in;
    logic                        range_in;
    logic                        in_ok;
    logic                        in_write;
    logic [pbm_pkg::COUNT_W-1:0] in_cnt;
    logic                        in_walk;
    logic [ADDR_W-1:0]           in_word;
    logic [OFF_W-1:0]            in_off;

    logic [K_W-1:0]              avail;
    logic [K_W-1:0]              take;
    logic                        last;
    logic [WORD_BITS-1:0]        mask;
    logic                        use_op;
    logic                        rsp_fire;
    logic [pbm_pkg::HINT_W-1:0]  hint_new;
    logic [pbm_pkg::HINT_W-1:0]  page_ext;

    assign accept = req_valid && req_ready;

    // bounds check of the incoming beat
    always_comb begin
        eff_lim   = (CMP_W'(page_limit) > CMP_W'(MAX_PAGES)) ? CMP_W'(MAX_PAGES)
                                                            : CMP_W'(page_limit);
        in_p      = CMP_W'(req.page_number);
        in_n      = CMP_W'(req.range_count);
        single_in = in_p < eff_lim;
        range_in  = (in_p + in_n) <= eff_lim;
        in_ok     = 1'b0;
        in_write  = 1'b0;
        in_cnt    = pbm_pkg::COUNT_W'(1);
        unique case (req.operation)
            pbm_pkg::OP_FREE_ONE, pbm_pkg::OP_USE_ONE: begin
                in_ok    = single_in;
                in_write = 1'b1;
            end
            pbm_pkg::OP_FREE_RANGE, pbm_pkg::OP_USE_RANGE: begin
                in_ok    = range_in;
                in_write = 1'b1;
                in_cnt   = req.range_count;
            end
            pbm_pkg::OP_QUERY: begin
                in_ok = single_in;
            end
            pbm_pkg::OP_FILL: begin
                in_ok = 1'b1;
            end
            default: begin
                in_ok = 1'b0;
            end
        endcase
        in_walk = in_ok && in_write && (in_cnt != '0);
        in_word = ADDR_W'(req.page_number / WORD_BITS);
        in_off  = OFF_W'(req.page_number % WORD_BITS);
    end

    // bits of the current word covered by the walk
    always_comb begin
        avail  = K_W'(WORD_BITS) - K_W'(off_reg);
        last   = rem_reg <= pbm_pkg::COUNT_W'(avail);
        take   = last ? K_W'(rem_reg) : avail;
        use_op = (op_reg == pbm_pkg::OP_USE_ONE) || (op_reg == pbm_pkg::OP_USE_RANGE);
        for (int j = 0; j < WORD_BITS; j++) begin
            mask[j] = (K_W'(j) >= K_W'(off_reg)) && (K_W'(j) < (K_W'(off_reg) + take));
        end
    end

    // hint after the current operation
    always_comb begin
        page_ext = pbm_pkg::HINT_W'(page_reg);
        hint_new = hint_reg;
        if (ok_reg) begin
            unique case (op_reg)
                pbm_pkg::OP_FREE_ONE, pbm_pkg::OP_FREE_RANGE: begin
                    if (page_ext < hint_reg) begin
                        hint_new = page_ext;
                    end
                end
                pbm_pkg::OP_USE_ONE: begin
                    if (page_ext == hint_reg) begin
                        hint_new = page_ext + pbm_pkg::HINT_W'(1);
                    end
                end
                pbm_pkg::OP_USE_RANGE: begin
                    if (page_ext <= hint_reg) begin
                        hint_new = page_ext + count_reg;
                    end
                end
                pbm_pkg::OP_FILL: begin
                    hint_new = '0;
                end
                default: begin
                    hint_new = hint_reg;
                end
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pbm_pkg::ST_SWEEP: begin
                if (sweep_reg == LAST_WORD) begin
                    state_next = sweep_rsp_reg ? pbm_pkg::ST_FINISH : pbm_pkg::ST_IDLE;
                end
            end
            pbm_pkg::ST_IDLE: begin
                if (req_valid) begin
                    if (req.operation == pbm_pkg::OP_FILL) begin
                        state_next = pbm_pkg::ST_SWEEP;
                    end else if (in_walk) begin
                        state_next = pbm_pkg::ST_WALK_WR;
                    end else begin
                        state_next = pbm_pkg::ST_FINISH;
                    end
                end
            end
            pbm_pkg::ST_WALK_RD: begin
                state_next = pbm_pkg::ST_WALK_WR;
            end
            pbm_pkg::ST_WALK_WR: begin
                if (!last) begin
                    state_next = pbm_pkg::ST_WALK_RD;
                end else if (rsp_ready) begin
                    state_next = pbm_pkg::ST_IDLE;
                end else begin
                    state_next = pbm_pkg::ST_FINISH;
                end
            end
            pbm_pkg::ST_FINISH: begin
                if (rsp_ready) begin
                    state_next = pbm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pbm_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs: memory ports, handshakes and result
    always_comb begin
        req_ready = state_reg == pbm_pkg::ST_IDLE;
        rsp_valid = (state_reg == pbm_pkg::ST_FINISH) ||
                    ((state_reg == pbm_pkg::ST_WALK_WR) && last);
        rd_en     = accept || (state_reg == pbm_pkg::ST_WALK_RD);
        rd_addr   = (state_reg == pbm_pkg::ST_IDLE) ? in_word : word_reg;
        wr_en     = (state_reg == pbm_pkg::ST_SWEEP) || (state_reg == pbm_pkg::ST_WALK_WR);
        wr_addr   = word_reg;
        wr_data   = use_op ? (rd_data | mask) : (rd_data & ~mask);
        if (state_reg == pbm_pkg::ST_SWEEP) begin
            wr_addr = sweep_reg;
            wr_data = {WORD_BITS{fill_reg}};
        end
        rsp.ok             = ok_reg;
        rsp.page_used      = (op_reg == pbm_pkg::OP_QUERY) && ok_reg && rd_data[off_reg];
        rsp.next_free_hint = hint_new;
    end

    assign rsp_fire = rsp_valid && rsp_ready;

    // control registers, reset starts the sweep pass with all ones
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pbm_pkg::ST_SWEEP;
            sweep_reg     <= '0;
            sweep_rsp_reg <= 1'b0;
            fill_reg      <= 1'b1;
            hint_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == pbm_pkg::ST_SWEEP) begin
                sweep_reg <= sweep_reg + ADDR_W'(1);
            end
            if (accept) begin
                sweep_reg     <= '0;
                sweep_rsp_reg <= 1'b1;
                fill_reg      <= req.fill_value;
            end
            if (rsp_fire) begin
                hint_reg <= hint_new;
            end
        end
    end

    // request capture and walk cursor
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= req.operation;
            page_reg  <= req.page_number;
            count_reg <= req.range_count;
            ok_reg    <= in_ok;
            word_reg  <= in_word;
            off_reg   <= in_off;
            rem_reg   <= in_cnt;
        end else if (state_reg == pbm_pkg::ST_WALK_WR) begin
            word_reg <= word_reg + ADDR_W'(1);
            off_reg  <= '0;
            rem_reg  <= rem_reg - pbm_pkg::COUNT_W'(take);
        end
    end

endmodule

// ===== hdl/page_bitmap_allocator.sv =====
// page bitmap allocator top level: limit register, map memory, controller, result register
// m_valid rises in the same cycle as the controller returns to idle after a result
// single-page ops read and write one map word, queries only read it, range ops read and write each map word they touch
// fill writes every map word, one word written per cycle
// a result beat not taken by m_ready holds the controller until the result register drains
// reset starts a pass writing all ones to every map word
module page_bitmap_allocator #(
    parameter int unsigned MAX_PAGES = 65536,
    parameter int unsigned WORD_BITS = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [pbm_pkg::LIMIT_W-1:0] cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  pbm_pkg::req_t               s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output pbm_pkg::rsp_t               m_data
);

    localparam int unsigned DEPTH  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [pbm_pkg::LIMIT_W-1:0] page_limit_reg;
    logic                        out_valid_reg;
    pbm_pkg::rsp_t               out_data_reg;

    pbm_pkg::rsp_t               rsp;
    logic                        rsp_valid;
    logic                        rsp_ready;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [WORD_BITS-1:0]        wr_data;
    logic                        rd_en;
    logic [ADDR_W-1:0]           rd_addr;
    logic [WORD_BITS-1:0]        rd_data;

    // page limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_limit_reg <= pbm_pkg::LIMIT_RESET;
        end else if (cfg_wr_en) begin
            page_limit_reg <= cfg_wr_data;
        end
    end

    // result register, refilled in the cycle the held beat leaves
    assign rsp_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (rsp_ready) begin
            out_valid_reg <= rsp_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rsp_valid && rsp_ready) begin
            out_data_reg <= rsp;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // map memory
    pbm_map_ram #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .ADDR_W    (ADDR_W)
    ) u_map_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // controller
    pbm_ctrl #(
        .MAX_PAGES (MAX_PAGES),
        .WORD_BITS (WORD_BITS),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .page_limit (page_limit_reg),
        .req        (s_data),
        .req_valid  (s_valid),
        .req_ready  (s_ready),
        .rsp        (rsp),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

endmodule
